>>> rtl/root_seeded_component_walk_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the root seeded component walk core
// Each macro expects clk and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef ROOT_SEEDED_COMPONENT_WALK_CORE_MACROS_SVH
`define ROOT_SEEDED_COMPONENT_WALK_CORE_MACROS_SVH

// same-cycle implication
`define RSCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rscw_pkg.sv
// ----------------------------------------------------------------------------
// rscw_pkg
// Shared types and constants for the root seeded component walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rscw_pkg;

  // field widths fixed by the interface
  localparam int NODE_W = 5;
  localparam int CNT_W  = 6;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

  // request modes
  localparam logic [1:0] MODE_FLAGS  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  // degree flag codes: bit0 in-degree zero, bit1 out-degree zero
  localparam logic [1:0] FLAG_ROOT = 2'd1;
  localparam logic [1:0] FLAG_LEAF = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_CHECK,
    ST_END,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // load request taken this cycle
    logic start_run;  // run request taken this cycle
    logic walk;       // tables addressed by the walk, not the scan/load
    logic root_load;  // scan found an unvisited root
    logic scan_next;  // step scan index
    logic adj_read;   // fetch neighbour j of stack top
    logic pop;        // stack top exhausted
    logic push;       // discover fetched neighbour
    logic skip;       // fetched neighbour unusable
    logic comp_end;   // flush last node of component
    logic emit_done;  // issue final result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic run_req;    // input mode is a run
    logic scan_end;   // scan index reached the limit
    logic root_hit;   // scan index is an unvisited root
    logic nbr_end;    // no neighbours left for stack top
    logic last_pop;   // popping the final stack entry
    logic cand_ok;    // fetched neighbour in range and unvisited
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

>>> rtl/rscw_ctrl.sv
// ----------------------------------------------------------------------------
// rscw_ctrl
// Sequencer for loading, root scan and depth-first walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rscw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rscw_pkg::sts_t sts,
  output rscw_pkg::cmd_t cmd
);

  rscw_pkg::state_t state_r;
  rscw_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rscw_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rscw_pkg::ST_IDLE: begin
        if (in_valid && sts.run_req) state_nxt = rscw_pkg::ST_SCAN;
      end
      rscw_pkg::ST_SCAN: begin
        if (sts.scan_end)      state_nxt = rscw_pkg::ST_DONE;
        else if (sts.root_hit) state_nxt = rscw_pkg::ST_READ;
      end
      rscw_pkg::ST_READ: begin
        if (!sts.nbr_end)      state_nxt = rscw_pkg::ST_CHECK;
        else if (sts.last_pop) state_nxt = rscw_pkg::ST_END;
      end
      rscw_pkg::ST_CHECK: begin
        if (!sts.cand_ok || sts.out_free) state_nxt = rscw_pkg::ST_READ;
      end
      rscw_pkg::ST_END: begin
        if (sts.out_free) state_nxt = rscw_pkg::ST_SCAN;
      end
      rscw_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = rscw_pkg::ST_IDLE;
      end
      default: state_nxt = rscw_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rscw_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load      = in_valid && !sts.run_req;
        cmd.start_run = in_valid && sts.run_req;
      end
      rscw_pkg::ST_SCAN: begin
        if (!sts.scan_end) begin
          cmd.root_load = sts.root_hit;
          cmd.scan_next = !sts.root_hit;
        end
      end
      rscw_pkg::ST_READ: begin
        cmd.walk     = 1'b1;
        cmd.adj_read = !sts.nbr_end;
        cmd.pop      = sts.nbr_end;
      end
      rscw_pkg::ST_CHECK: begin
        cmd.walk = 1'b1;
        cmd.push = sts.cand_ok && sts.out_free;
        cmd.skip = !sts.cand_ok;
      end
      rscw_pkg::ST_END: begin
        cmd.comp_end = sts.out_free;
      end
      rscw_pkg::ST_DONE: begin
        cmd.emit_done = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/rscw_dp.sv
// ----------------------------------------------------------------------------
// rscw_dp
// Graph tables, adjacency memory, walk stack and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "root_seeded_component_walk_core_macros.svh"

module rscw_dp #(
  parameter int MAX_NODES  = 32,
  parameter int MAX_DEGREE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rscw_pkg::cmd_t                cmd,
  output rscw_pkg::sts_t                sts,
  input  logic [1:0]                    in_mode,
  input  logic [rscw_pkg::NODE_W-1:0]   in_node,
  input  logic [rscw_pkg::NODE_W-1:0]   in_neighbour,
  input  logic                          in_in_zero,
  input  logic                          in_out_zero,
  input  logic                          cfg_we,
  input  logic [rscw_pkg::CNT_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rscw_pkg::NODE_W-1:0]   out_component,
  output logic [rscw_pkg::NODE_W-1:0]   out_member,
  output logic                          out_is_root,
  output logic                          out_is_leaf,
  output logic                          out_component_end,
  output logic                          out_done_res,
  output logic                          out_overflow
);

  // node indices are 5 bits, so at most 32 nodes can ever be stored
  localparam int ND  = (MAX_NODES < 32) ? MAX_NODES : 32;
  localparam int NIW = $clog2(ND);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int SPW = $clog2(ND + 1);
  localparam int AD  = ND * MAX_DEGREE;
  localparam int AW  = $clog2(AD);
  localparam int NW  = rscw_pkg::NODE_W;
  localparam int KW  = rscw_pkg::CNT_W;

  // tables
  logic [CW-1:0]  ncount_r [ND];
  logic [1:0]     flags_r  [ND];
  logic [ND-1:0]  visited_r;
  logic [NW-1:0]  stack_r  [ND];
  logic [NW-1:0]  adj_mem  [AD];
  logic [NW-1:0]  adj_rdata_r;

  // walk registers
  logic [KW-1:0]  node_count_r;
  logic [KW-1:0]  scan_r;
  logic [SPW-1:0] sp_r;
  logic [CW-1:0]  j_r;
  logic [NW-1:0]  comp_r;
  logic           dropped_r;

  // pending node result, held until its successor or component end is known
  logic           pend_valid_r;
  logic [NW-1:0]  pend_member_r;
  logic           pend_root_r;
  logic           pend_leaf_r;

  // output register
  logic           out_valid_r;
  logic [NW-1:0]  out_component_r;
  logic [NW-1:0]  out_member_r;
  logic           out_root_r;
  logic           out_leaf_r;
  logic           out_end_r;
  logic           out_done_r;
  logic           out_ovf_r;

  logic [KW-1:0]  limit;
  logic           node_ok;
  logic [NIW-1:0] in_idx;
  logic [NIW-1:0] r_idx;
  logic [NIW-1:0] v_idx;
  logic [NIW-1:0] top_idx;
  logic [SPW-1:0] sp_m1;
  logic [NW-1:0]  top;
  logic [NIW-1:0] nc_idx;
  logic [NIW-1:0] fl_idx;
  logic [CW-1:0]  nc_rd;
  logic [1:0]     fl_rd;
  logic           vis_rd;
  logic           out_free;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;

  // address and lookup
  assign limit   = (node_count_r < KW'(MAX_NODES)) ? node_count_r : KW'(MAX_NODES);
  assign node_ok = {1'b0, in_node} < KW'(ND);
  assign in_idx  = in_node[NIW-1:0];
  assign r_idx   = scan_r[NIW-1:0];
  assign v_idx   = adj_rdata_r[NIW-1:0];
  assign sp_m1   = sp_r - 1'b1;
  assign top     = stack_r[sp_m1[NIW-1:0]];
  assign top_idx = top[NIW-1:0];

  // one read port per table, steered by the walk phase
  assign nc_idx  = cmd.walk ? top_idx : in_idx;
  assign fl_idx  = cmd.walk ? v_idx : r_idx;
  assign nc_rd   = ncount_r[nc_idx];
  assign fl_rd   = flags_r[fl_idx];
  assign vis_rd  = visited_r[fl_idx];

  assign out_free = !out_valid_r || out_ready;

  // status
  assign sts.run_req  = (in_mode == rscw_pkg::MODE_RUN);
  assign sts.scan_end = (scan_r == limit);
  assign sts.root_hit = (scan_r < KW'(ND)) && (fl_rd == rscw_pkg::FLAG_ROOT) && !vis_rd;
  assign sts.nbr_end  = (j_r == nc_rd);
  assign sts.last_pop = (sp_r == SPW'(1));
  assign sts.cand_ok  = ({1'b0, adj_rdata_r} < limit) && !vis_rd;
  assign sts.out_free = out_free;

  // adjacency memory ports
  assign mem_we    = cmd.load && (in_mode == rscw_pkg::MODE_APPEND) && node_ok &&
                     (nc_rd < CW'(MAX_DEGREE));
  assign mem_waddr = AW'(AW'(in_idx) * AW'(MAX_DEGREE) + AW'(nc_rd));
  assign mem_raddr = AW'(AW'(top_idx) * AW'(MAX_DEGREE) + AW'(j_r));

  always_ff @(posedge clk) begin
    if (mem_we) adj_mem[mem_waddr] <= in_neighbour;
  end

  always_ff @(posedge clk) begin
    if (cmd.adj_read) adj_rdata_r <= adj_mem[mem_raddr];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= rscw_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // node flags and neighbour counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) begin
        ncount_r[i] <= '0;
        flags_r[i]  <= '0;
      end
      dropped_r <= 1'b0;
    end else if (cmd.load && node_ok) begin
      if (in_mode == rscw_pkg::MODE_FLAGS) begin
        flags_r[in_idx]  <= {in_out_zero, in_in_zero};
        ncount_r[in_idx] <= '0;
      end else if (in_mode == rscw_pkg::MODE_APPEND) begin
        if (mem_we) ncount_r[in_idx] <= nc_rd + 1'b1;
        else        dropped_r        <= 1'b1;
      end
    end
  end

  // visited map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
    end else if (cmd.start_run) begin
      visited_r <= '0;
    end else if (cmd.root_load) begin
      visited_r[r_idx] <= 1'b1;
    end else if (cmd.push) begin
      visited_r[v_idx] <= 1'b1;
    end
  end

  // walk stack contents
  always_ff @(posedge clk) begin
    if (cmd.root_load) stack_r[0] <= scan_r[NW-1:0];
    else if (cmd.push) stack_r[sp_r[NIW-1:0]] <= adj_rdata_r;
  end

  // scan index, stack pointer, neighbour index, component number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      sp_r   <= '0;
      j_r    <= '0;
      comp_r <= '0;
    end else begin
      if (cmd.start_run) begin
        scan_r <= '0;
        comp_r <= '0;
      end
      if (cmd.scan_next) scan_r <= scan_r + 1'b1;
      if (cmd.root_load) begin
        sp_r <= SPW'(1);
        j_r  <= '0;
      end
      if (cmd.push) begin
        sp_r <= sp_r + 1'b1;
        j_r  <= '0;
      end
      if (cmd.pop) begin
        sp_r <= sp_m1;
        j_r  <= '0;
      end
      if (cmd.skip) j_r <= j_r + 1'b1;
      if (cmd.comp_end) begin
        scan_r <= scan_r + 1'b1;
        comp_r <= comp_r + 1'b1;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.root_load || cmd.push) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.comp_end) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      pend_member_r <= scan_r[NW-1:0];
      pend_root_r   <= 1'b1;
      pend_leaf_r   <= 1'b0;
    end else if (cmd.push) begin
      pend_member_r <= adj_rdata_r;
      pend_root_r   <= (fl_rd == rscw_pkg::FLAG_ROOT);
      pend_leaf_r   <= (fl_rd == rscw_pkg::FLAG_LEAF);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push || cmd.comp_end || cmd.emit_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.comp_end) begin
      out_component_r <= comp_r;
      out_member_r    <= pend_member_r;
      out_root_r      <= pend_root_r;
      out_leaf_r      <= pend_leaf_r;
      out_end_r       <= cmd.comp_end;
      out_done_r      <= 1'b0;
      out_ovf_r       <= 1'b0;
    end else if (cmd.emit_done) begin
      out_component_r <= '0;
      out_member_r    <= '0;
      out_root_r      <= 1'b0;
      out_leaf_r      <= 1'b0;
      out_end_r       <= 1'b0;
      out_done_r      <= 1'b1;
      out_ovf_r       <= dropped_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_component     = out_component_r;
  assign out_member        = out_member_r;
  assign out_is_root       = out_root_r;
  assign out_is_leaf       = out_leaf_r;
  assign out_component_end = out_end_r;
  assign out_done_res      = out_done_r;
  assign out_overflow      = out_ovf_r;

  // checks
  `RSCW_ASSERT_IMP(a_push_slot, cmd.push, out_free, "node discovered with output busy")
  `RSCW_ASSERT_IMP(a_pend_held, cmd.push || cmd.comp_end, pend_valid_r, "no pending node to flush")
  `RSCW_ASSERT_IMP(a_done_clean, cmd.emit_done, !pend_valid_r, "done with node still pending")
  `RSCW_ASSERT_NXT(a_root_sp, cmd.root_load, sp_r == SPW'(1), "stack not seeded by root")

endmodule

>>> rtl/root_seeded_component_walk_core.sv
// ----------------------------------------------------------------------------
// root_seeded_component_walk_core
// Depth-first component walk over a small loaded directed graph.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready: mode 0 stores a node's degree flags and empties its
//   list, mode 1 appends a neighbour, mode 2 runs the walk, mode 3 is taken
//   and ignored. Loads are taken back to back, with no result.
//   A run streams node results on out_valid/out_ready in discovery order,
//   then one done result with the overflow flag; input waits until then.
//   cfg_we/cfg_wdata write node_count; the user writes it only while the
//   core is idle; the core itself does not enforce this. A run visits each
//   scanned index, examines each neighbour by a registered adjacency read
//   and then a check, pops the stack, ends each component and issues done;
//   lists restart after each return. A node is held until its successor or
//   component end is known, so the root's result waits for the next push
//   or for its component end. Reset clears flags, neighbour counts, visited
//   map and overflow flag, and sets node_count to 32. A stalled receiver
//   holds the output register and the walk waits at its next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module root_seeded_component_walk_core #(
  parameter int MAX_NODES  = 32,
  parameter int MAX_DEGREE = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [rscw_pkg::NODE_W-1:0] in_node,
  input  logic [rscw_pkg::NODE_W-1:0] in_neighbour,
  input  logic                        in_in_zero,
  input  logic                        in_out_zero,
  input  logic                        cfg_we,
  input  logic [rscw_pkg::CNT_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rscw_pkg::NODE_W-1:0] out_component,
  output logic [rscw_pkg::NODE_W-1:0] out_member,
  output logic                        out_is_root,
  output logic                        out_is_leaf,
  output logic                        out_component_end,
  output logic                        out_done_res,
  output logic                        out_overflow
);

  rscw_pkg::cmd_t cmd;
  rscw_pkg::sts_t sts;

  // sequencer
  rscw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables, stack and result registers
  rscw_dp #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_node           (in_node),
    .in_neighbour      (in_neighbour),
    .in_in_zero        (in_in_zero),
    .in_out_zero       (in_out_zero),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_component     (out_component),
    .out_member        (out_member),
    .out_is_root       (out_is_root),
    .out_is_leaf       (out_is_leaf),
    .out_component_end (out_component_end),
    .out_done_res      (out_done_res),
    .out_overflow      (out_overflow)
  );

endmodule
